// ===== src/tcc_pkg.sv =====
// tcc_pkg: shared types, constants and per-byte judging functions for the
// text content classifier. No dependencies; used by tcc_scan and the top level.
package tcc_pkg;

   // scan window and delay line geometry
   localparam int SCAN_BYTES  = 512;
   localparam int SCAN_CNT_W  = $clog2(SCAN_BYTES + 1);
   localparam int WIN         = 7;
   localparam int FLUSH_STEPS = WIN - 2;
   localparam int GLOBL_LEN   = 5;

   // xmail line pattern repeats every 22 judged bytes
   localparam logic [4:0] XMAIL_LAST_PHASE = 5'd21;

   // class codes
   localparam logic [2:0] CLS_BINARY    = 3'd0;
   localparam logic [2:0] CLS_COMMANDS  = 3'd1;
   localparam logic [2:0] CLS_ASM       = 3'd2;
   localparam logic [2:0] CLS_FORMATTER = 3'd3;
   localparam logic [2:0] CLS_YACC      = 3'd4;
   localparam logic [2:0] CLS_XMAIL     = 3'd5;
   localparam logic [2:0] CLS_C         = 3'd6;
   localparam logic [2:0] CLS_TEXT      = 3'd7;

   // characters of interest
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;

   // "globl", first letter in element 0
   localparam logic [GLOBL_LEN-1:0][7:0] GLOBL_WORD = {8'h6C, 8'h62, 8'h6F, 8'h6C, 8'h67};

   // delay line plus the flags that judging updates
   typedef struct packed {
      logic [WIN-1:0][7:0] win_bytes;
      logic [WIN-1:0]      win_valid;
      logic                line_start;
      logic [4:0]          phase;
      logic                brace;
      logic                hash_semi;
      logic                xmail;
      logic [2:0]          verdict;
      logic                found;
   } tcc_judge_type;

   localparam tcc_judge_type JUDGE_RESET = '{
      win_bytes:  '0,
      win_valid:  '0,
      line_start: 1'b1,
      phase:      '0,
      brace:      1'b0,
      hash_semi:  1'b0,
      xmail:      1'b0,
      verdict:    CLS_BINARY,
      found:      1'b0
   };

   // one word handed from the input register to the scanner
   typedef struct packed {
      logic       step;
      logic       last;
      logic       exec;
      logic [7:0] byte_value;
   } tcc_step_type;

   // printable or ordinary control character
   function automatic logic is_plain(input logic [7:0] b);
      return b inside {[8'h08:8'h0D], [8'h20:8'h7E]};
   endfunction

   // push one byte into the newest slot of the delay line
   function automatic tcc_judge_type shift_in(input tcc_judge_type s,
                                              input logic [7:0] b,
                                              input logic v);
      tcc_judge_type r;
      r = s;
      r.win_bytes = {b, s.win_bytes[WIN-1:1]};
      r.win_valid = {v, s.win_valid[WIN-1:1]};
      return r;
   endfunction

   // judge the byte in slot 1; slot 0 is the previous byte, slots 2..6 follow
   function automatic tcc_judge_type judge(input tcc_judge_type s);
      tcc_judge_type r;
      logic [7:0]    c;
      logic [7:0]    prev;
      logic [7:0]    next;
      logic          prev_ok;
      logic          globl;
      logic          done;
      logic [4:0]    pos;
      r       = s;
      c       = s.win_bytes[1];
      prev    = s.win_bytes[0];
      next    = s.win_bytes[2];
      prev_ok = s.win_valid[0];
      done    = 1'b0;
      globl   = 1'b1;
      pos     = (s.phase == XMAIL_LAST_PHASE) ? 5'd0 : s.phase + 5'd1;
      for (int k = 0; k < GLOBL_LEN; k++) begin
         if (!s.win_valid[2 + k] || s.win_bytes[2 + k] != GLOBL_WORD[k]) begin
            globl = 1'b0;
         end
      end
      if (s.win_valid[1] && !s.found) begin
         // decisive events
         if (c == CH_DOT && globl) begin
            r.verdict = CLS_ASM;
            done      = 1'b1;
         end else if (s.line_start && c == CH_DOT) begin
            r.verdict = CLS_FORMATTER;
            done      = 1'b1;
         end else if (s.line_start && c == CH_COLON) begin
            r.verdict = CLS_COMMANDS;
            done      = 1'b1;
         end else if (s.line_start && c == CH_PERCENT && s.win_valid[2] &&
                      (next == CH_PERCENT || next == CH_LBRACE || next == CH_RBRACE)) begin
            r.verdict = CLS_YACC;
            done      = 1'b1;
         end
         r.found = done;
         // evidence flags, line tracking and xmail phase
         if (!done) begin
            if (s.line_start && c == CH_HASH) begin
               r.hash_semi = 1'b1;
            end
            if (c == CH_LBRACE || c == CH_RBRACE) begin
               r.brace = 1'b1;
            end
            if (c == CH_NL) begin
               r.line_start = 1'b1;
               if (prev_ok && prev == CH_SEMI) begin
                  r.hash_semi = 1'b1;
               end
               if (pos == 5'd0) begin
                  if (prev_ok && (prev == CH_SPACE || prev == CH_BANG)) begin
                     r.xmail = 1'b1;
                  end
               end else begin
                  r.xmail = 1'b0;
               end
            end else begin
               r.line_start = 1'b0;
            end
            r.phase = pos;
         end
      end
      return r;
   endfunction

endpackage

// ===== src/tcc_scan.sv =====
// tcc_scan: classifier state registers and the per-byte judging step,
// including the end-of-file drain of the lookahead. Depends on tcc_pkg.
module tcc_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  tcc_pkg::tcc_step_type step,
   output logic [2:0]            class_code
);

   tcc_pkg::tcc_judge_type          judge_ff, judge_in;
   logic [tcc_pkg::SCAN_CNT_W-1:0]  seen_ff, seen_in;
   logic                            binary_ff, binary_in;
   tcc_pkg::tcc_judge_type          scan_state;
   tcc_pkg::tcc_judge_type          drain_state;

   // take in one byte, then drain the lookahead for the final verdict
   always_comb begin
      scan_state = judge_ff;
      seen_in    = seen_ff;
      binary_in  = binary_ff;
      if (step.step && seen_ff < tcc_pkg::SCAN_CNT_W'(tcc_pkg::SCAN_BYTES)) begin
         seen_in = seen_ff + tcc_pkg::SCAN_CNT_W'(1);
         if (!tcc_pkg::is_plain(step.byte_value)) begin
            binary_in = 1'b1;
         end
         scan_state = tcc_pkg::shift_in(scan_state, step.byte_value, 1'b1);
         if (scan_state.win_valid[tcc_pkg::WIN-1]) begin
            scan_state = tcc_pkg::judge(scan_state);
         end
      end
      drain_state = scan_state;
      for (int k = 0; k < tcc_pkg::FLUSH_STEPS; k++) begin
         drain_state = tcc_pkg::judge(tcc_pkg::shift_in(drain_state, 8'h00, 1'b0));
      end
      judge_in = scan_state;
      if (step.step && step.last) begin
         judge_in  = tcc_pkg::JUDGE_RESET;
         seen_in   = '0;
         binary_in = 1'b0;
      end
   end

   // class priority: binary, commands, first event, xmail, C, text
   always_comb begin
      if (binary_in || (step.step && step.last && binary_ff)) begin
         class_code = tcc_pkg::CLS_BINARY;
      end else if (step.exec) begin
         class_code = tcc_pkg::CLS_COMMANDS;
      end else if (drain_state.found) begin
         class_code = drain_state.verdict;
      end else if (drain_state.xmail) begin
         class_code = tcc_pkg::CLS_XMAIL;
      end else if (drain_state.hash_semi && drain_state.brace) begin
         class_code = tcc_pkg::CLS_C;
      end else begin
         class_code = tcc_pkg::CLS_TEXT;
      end
      // binary flag including the current byte, before the end-of-file clear
      if (step.step && seen_ff < tcc_pkg::SCAN_CNT_W'(tcc_pkg::SCAN_BYTES) &&
          !tcc_pkg::is_plain(step.byte_value)) begin
         class_code = tcc_pkg::CLS_BINARY;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         judge_ff  <= tcc_pkg::JUDGE_RESET;
         seen_ff   <= '0;
         binary_ff <= 1'b0;
      end else begin
         judge_ff  <= judge_in;
         seen_ff   <= seen_in;
         binary_ff <= binary_in;
      end
   end

`ifndef ASSERT_OFF
   a_file_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step.step && step.last) |=> (seen_ff == '0 && !judge_ff.found && !binary_ff))
      else $error("scanner state not cleared after last byte");
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= tcc_pkg::SCAN_CNT_W'(tcc_pkg::SCAN_BYTES))
      else $error("byte count ran past the scan window");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step.step |=> ($stable(seen_ff) && $stable(binary_ff)))
      else $error("scanner state moved without a word");
`endif

endmodule

// ===== src/text_content_classifier_unit.sv =====
// text_content_classifier_unit: top level with the input register, the
// result register and the valid/stall handshake. Depends on tcc_pkg, tcc_scan.

// Classifies a file as binary, commands, assembler, formatter, yacc/lex,
// xmail, C or text from its leading bytes, fed one byte per word on the req_
// channel. One byte is taken every cycle unless req_stall is high; a byte
// is judged once five later bytes fill the seven-byte delay line, and the
// class code of the word marked last_byte is registered for the rsp_ channel
// as that word leaves the input register. The end-of-file drain of the five
// lookahead bytes happens in that same cycle, so the next file may start in
// the very next word. Only the first 512 bytes are inspected. The input side
// stalls only while a last byte waits behind a result that is itself stalled.
module text_content_classifier_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   input  logic       req_executable,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_class_code
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  in_exec_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_class_ff, rsp_class_in;
   logic                  advance;
   logic                  take;
   logic [2:0]            scan_class;
   tcc_pkg::tcc_step_type step;

   // input register moves unless a last byte meets a stalled result
   assign advance   = !in_valid_ff || !in_last_ff || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign take      = req_valid && advance;

   assign step.step       = in_valid_ff && advance;
   assign step.last       = in_last_ff;
   assign step.exec       = in_exec_ff;
   assign step.byte_value = in_byte_ff;

   tcc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .class_code (scan_class)
   );

   // next values for input and result registers
   always_comb begin
      in_valid_in  = advance ? req_valid : in_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_class_in = rsp_class_ff;
      if (step.step && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = scan_class;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last_byte;
         in_exec_ff <= req_executable;
      end
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_code = rsp_class_ff;

`ifndef ASSERT_OFF
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && advance) |=> rsp_valid_ff)
      else $error("last byte processed without a result word");
   a_word_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff && advance))
      else $error("result word without a last byte");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");
`endif

endmodule
